[rtl/dblr_pkg.sv]
// Shared constants and types for the double-buffered line receiver.
package dblr_pkg;

    localparam int BUF_DEPTH   = 32;
    localparam int MAX_RESULTS = 32;
    localparam int ADDR_W      = $clog2(BUF_DEPTH);
    localparam int MEM_AW      = ADDR_W + 1;
    localparam int MEM_DEPTH   = 2 * BUF_DEPTH;
    localparam int READ_LIMIT  = (BUF_DEPTH < MAX_RESULTS) ? BUF_DEPTH : MAX_RESULTS;
    localparam int POS_W       = 5;

    localparam logic [7:0]       CR_CODE        = 8'd13;
    localparam logic [POS_W-1:0] LINE_LEN_RESET = 5'd31;

    // Store access request: {line select, index} addresses
    typedef struct packed {
        logic              wr_en;
        logic [MEM_AW-1:0] wr_addr;
        logic [7:0]        wr_data;
        logic              clr_en;
        logic [MEM_AW-1:0] clr_addr;
        logic              rd_en;
        logic [MEM_AW-1:0] rd_addr;
    } store_req_t;

endpackage

[rtl/double_buffered_line_receiver_unit.sv]
// Top level of the double-buffered (ping-pong) line receiver.
// Slave stream (s_*): one transaction per item. s_tuser is the mode:
//   0 = s_tdata is a received byte, 1 = read out a ready line, buffer A first.
//   A byte of 13 (carriage return), or any byte once the write position
//   has reached max_line_length, closes the line, flips the fill buffer
//   and is not stored.
// Master stream (m_*): read results. m_tdata is the line byte, m_tuser[0]
//   marks a real byte, m_tuser[1] reports that a line is still ready, and
//   m_tlast flags the final result of one read request.
// Config: cfg_wr_en writes cfg_wr_data to max_line_length (reset 31);
//   write it only while the block is idle.
// Timing: a received byte is stored as it is accepted. A read request is
//   accepted and issues the first RAM read, whose data returns in the next
//   cycle; then one result leaves per cycle while the master side is not
//   stalled. The pace is set by the single RAM read port and its registered read data.
// Reset clears all entries at once through valid bits; there is no
// clearing pass. A stalled master side holds the output register and
// freezes the readout; the input side stays blocked until the read ends.
module double_buffered_line_receiver_unit
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,     // [7:0] rx_byte
    input  logic                       s_tuser,     // [0] mode
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,     // [7:0] data_byte
    output logic [1:0]                 m_tuser,     // [0] byte_valid, [1] message_ready
    output logic                       m_tlast,     // last
    input  logic                       cfg_wr_en,
    input  logic [dblr_pkg::POS_W-1:0] cfg_wr_data  // max_line_length
);
    import dblr_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_FIRST = 5'b00010,
        S_NEXT  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_EMPTY = 5'b10000
    } state_t;

    state_t            state_reg, state_next;
    logic              fill_sel_reg, fill_sel_next;
    logic              ready_a_reg, ready_a_next;
    logic              ready_b_reg, ready_b_next;
    logic [POS_W-1:0]  pos_reg, pos_next;
    logic [POS_W-1:0]  max_len_reg;

    // readout payload
    logic              rd_sel_reg, rd_sel_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [7:0]        hold_reg, hold_next;

    // output register
    logic              out_valid_reg;
    logic [7:0]        out_data_reg;
    logic              out_bv_reg;
    logic              out_last_reg;
    logic              out_rdy_reg;

    store_req_t        store_req;
    logic [7:0]        rd_byte;

    logic              in_accept;
    logic              slot_free;
    logic              more;
    logic              line_close;
    logic              emit;
    logic [7:0]        emit_data;
    logic              emit_bv;
    logic              emit_last;

    dblr_line_store u_store
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (store_req),
        .rd_byte (rd_byte)
    );

    assign s_tready  = (state_reg == S_IDLE);
    assign in_accept = s_tvalid && s_tready;
    assign slot_free = !out_valid_reg || m_tready;
    assign more      = (32'(idx_reg) + 1) < READ_LIMIT;
    assign line_close = (s_tdata == CR_CODE) || (pos_reg >= max_len_reg) ||
                        (32'(pos_reg) >= BUF_DEPTH);

    always_comb
    begin
        state_next    = state_reg;
        fill_sel_next = fill_sel_reg;
        ready_a_next  = ready_a_reg;
        ready_b_next  = ready_b_reg;
        pos_next      = pos_reg;
        rd_sel_next   = rd_sel_reg;
        idx_next      = idx_reg;
        hold_next     = hold_reg;
        store_req     = '0;
        emit          = 1'b0;
        emit_data     = 8'd0;
        emit_bv       = 1'b0;
        emit_last     = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_accept && !s_tuser)
                begin
                    if (line_close)
                    begin
                        fill_sel_next = ~fill_sel_reg;
                        if (!fill_sel_reg)
                        begin
                            ready_a_next = 1'b1;
                        end
                        else
                        begin
                            ready_b_next = 1'b1;
                        end
                        pos_next = '0;
                    end
                    else
                    begin
                        store_req.wr_en   = 1'b1;
                        store_req.wr_addr = {fill_sel_reg, ADDR_W'(pos_reg)};
                        store_req.wr_data = s_tdata;
                        pos_next          = pos_reg + POS_W'(1);
                    end
                end
                else if (in_accept)
                begin
                    if (!ready_a_reg && !ready_b_reg)
                    begin
                        state_next = S_EMPTY;
                    end
                    else
                    begin
                        // buffer A wins when both are ready
                        rd_sel_next = !ready_a_reg;
                        if (ready_a_reg)
                        begin
                            ready_a_next = 1'b0;
                        end
                        else
                        begin
                            ready_b_next = 1'b0;
                        end
                        store_req.rd_en   = 1'b1;
                        store_req.rd_addr = {!ready_a_reg, ADDR_W'(0)};
                        idx_next          = '0;
                        state_next        = S_FIRST;
                    end
                end
            end
            S_FIRST:
            begin
                if (rd_byte == 8'd0)
                begin
                    state_next = S_EMPTY;
                end
                else
                begin
                    hold_next          = rd_byte;
                    store_req.clr_en   = 1'b1;
                    store_req.clr_addr = {rd_sel_reg, idx_reg};
                    if (more)
                    begin
                        store_req.rd_en   = 1'b1;
                        store_req.rd_addr = {rd_sel_reg, idx_reg + ADDR_W'(1)};
                        idx_next          = idx_reg + ADDR_W'(1);
                        state_next        = S_NEXT;
                    end
                    else
                    begin
                        state_next = S_DRAIN;
                    end
                end
            end
            S_NEXT:
            begin
                if (slot_free)
                begin
                    emit      = 1'b1;
                    emit_data = hold_reg;
                    emit_bv   = 1'b1;
                    if (rd_byte != 8'd0)
                    begin
                        hold_next          = rd_byte;
                        store_req.clr_en   = 1'b1;
                        store_req.clr_addr = {rd_sel_reg, idx_reg};
                        if (more)
                        begin
                            store_req.rd_en   = 1'b1;
                            store_req.rd_addr = {rd_sel_reg, idx_reg + ADDR_W'(1)};
                            idx_next          = idx_reg + ADDR_W'(1);
                        end
                        else
                        begin
                            state_next = S_DRAIN;
                        end
                    end
                    else
                    begin
                        emit_last  = 1'b1;
                        state_next = S_IDLE;
                    end
                end
            end
            S_DRAIN:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_data  = hold_reg;
                    emit_bv    = 1'b1;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_EMPTY:
            begin
                if (slot_free)
                begin
                    emit       = 1'b1;
                    emit_last  = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_sel_reg  <= 1'b0;
            ready_a_reg   <= 1'b0;
            ready_b_reg   <= 1'b0;
            pos_reg       <= '0;
            max_len_reg   <= LINE_LEN_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            fill_sel_reg <= fill_sel_next;
            ready_a_reg  <= ready_a_next;
            ready_b_reg  <= ready_b_next;
            pos_reg      <= pos_next;
            if (cfg_wr_en)
            begin
                max_len_reg <= cfg_wr_data;
            end
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rd_sel_reg <= rd_sel_next;
        idx_reg    <= idx_next;
        hold_reg   <= hold_next;
        if (emit)
        begin
            out_data_reg <= emit_data;
            out_bv_reg   <= emit_bv;
            out_last_reg <= emit_last;
            // flags are final once the read transaction is taken
            out_rdy_reg  <= ready_a_reg || ready_b_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = {out_rdy_reg, out_bv_reg};
    assign m_tlast  = out_last_reg;

`ifndef SYNTH
    a_no_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (m_tdata == 8'd0 && m_tlast))
        else $error("non-byte result carries data or is not last");

    a_ready_drops: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && s_tuser && (ready_a_reg || ready_b_reg)) |=>
        ($countones({ready_a_reg, ready_b_reg}) ==
         $countones($past({ready_a_reg, ready_b_reg})) - 1))
        else $error("read did not consume exactly one ready line");

    a_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        store_req.wr_en |-> (state_reg == S_IDLE))
        else $error("store written during readout");

    a_first_has_read: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FIRST) |-> $past(store_req.rd_en))
        else $error("first readout cycle without a RAM read");
`endif

endmodule

[rtl/dblr_line_store.sv]
// Two line buffers in one synchronous RAM, with per-entry valid bits for reset and clear.
module dblr_line_store
(
    input  logic               clk,
    input  logic               rst_n,
    input  dblr_pkg::store_req_t req,
    output logic [7:0]         rd_byte
);
    import dblr_pkg::*;

    logic [7:0]           mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] valid_reg;
    logic [7:0]           rd_data_reg;
    logic                 rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        if (req.rd_en)
        begin
            rd_data_reg <= mem[req.rd_addr];
        end
    end

    // invalid entry reads as zero: covers reset and cleared entries
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.wr_en)
            begin
                valid_reg[req.wr_addr] <= 1'b1;
            end
            if (req.clr_en)
            begin
                valid_reg[req.clr_addr] <= 1'b0;
            end
            if (req.rd_en)
            begin
                rd_valid_reg <= valid_reg[req.rd_addr];
            end
        end
    end

    assign rd_byte = rd_valid_reg ? rd_data_reg : 8'd0;

endmodule
